// ===== hw/rtl/pfc_pkg.sv =====
package pfc_pkg;

  localparam int FMT_W  = 5;
  localparam int PIX_W  = 32;
  localparam int SIZE_W = 9;
  localparam int CFG_IDX_W = 2;

  // pixel format codes
  localparam logic [FMT_W-1:0] FMT_ARGB8  = 5'd0;
  localparam logic [FMT_W-1:0] FMT_XRGB8  = 5'd1;
  localparam logic [FMT_W-1:0] FMT_RGB8   = 5'd2;
  localparam logic [FMT_W-1:0] FMT_ABGR8  = 5'd3;
  localparam logic [FMT_W-1:0] FMT_XBGR8  = 5'd4;
  localparam logic [FMT_W-1:0] FMT_BGR8   = 5'd5;
  localparam logic [FMT_W-1:0] FMT_RGBA8  = 5'd6;
  localparam logic [FMT_W-1:0] FMT_RGBX8  = 5'd7;
  localparam logic [FMT_W-1:0] FMT_BGRA8  = 5'd8;
  localparam logic [FMT_W-1:0] FMT_BGRX8  = 5'd9;
  localparam logic [FMT_W-1:0] FMT_ARGB5  = 5'd10;
  localparam logic [FMT_W-1:0] FMT_RGB5   = 5'd11;
  localparam logic [FMT_W-1:0] FMT_ABGR5  = 5'd12;
  localparam logic [FMT_W-1:0] FMT_BGR5   = 5'd13;
  localparam logic [FMT_W-1:0] FMT_RGBA5  = 5'd14;
  localparam logic [FMT_W-1:0] FMT_BGRA5  = 5'd15;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 5'd16;
  localparam logic [FMT_W-1:0] FMT_BGR565 = 5'd17;
  localparam logic [FMT_W-1:0] FMT_L8     = 5'd18;
  localparam logic [FMT_W-1:0] FMT_PAL    = 5'd19;
  localparam logic [FMT_W-1:0] FMT_ANY    = 5'd20;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_FMT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_FMT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_SIZE = 2'd2;

  // request types
  localparam logic REQ_CONVERT   = 1'b0;
  localparam logic REQ_PAL_WRITE = 1'b1;

  typedef struct packed {
    logic [FMT_W-1:0] src;
    logic [FMT_W-1:0] dst;
  } pfc_fmt_t;

endpackage

// ===== hw/rtl/pixel_format_converter_top.sv =====
// conversion words pass stage one, then the result register; throughput: one word per
// clock while out_ready is high; palette writes take one input cycle and give no output
// palette lookup is a registered read of an internal memory in the accept cycle
// reset clears the pipeline valids and the format and palette size registers
// palette contents are not reset and must be written before use
module pixel_format_converter_top #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [pfc_pkg::PIX_W-1:0]      in_pixel_in,
  input  logic [7:0]                     in_entry_index,
  input  logic [pfc_pkg::PIX_W-1:0]      in_entry_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pfc_pkg::PIX_W-1:0]      out_pixel_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfc_pkg::SIZE_W-1:0]     cfg_data
);
  import pfc_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [SIZE_W-1:0] PAL_LIM = SIZE_W'(PALETTE_ENTRIES);

  logic [FMT_W-1:0]  src_fmt_r;
  logic [FMT_W-1:0]  dst_fmt_r;
  logic [SIZE_W-1:0] pal_size_r;

  logic [PIX_W-1:0]  pal_mem [PALETTE_ENTRIES];
  logic [PIX_W-1:0]  pal_data_r;

  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pixel_r;
  logic              s1_hit_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pixel_r;

  logic              out_free;
  logic              in_fire;
  logic              conv_fire;
  logic              wr_fire;
  logic [SIZE_W-1:0] pal_lim;
  logic              pal_hit;
  logic [PIX_W-1:0]  s1_pix;
  pfc_fmt_t          s1_fmt;
  logic [PIX_W-1:0]  conv_pixel;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r  <= FMT_ARGB8;
      dst_fmt_r  <= FMT_ARGB8;
      pal_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SRC_FMT:  src_fmt_r  <= cfg_data[FMT_W-1:0];
        CFG_DST_FMT:  dst_fmt_r  <= cfg_data[FMT_W-1:0];
        CFG_PAL_SIZE: pal_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_fire   = in_valid && in_ready;
  assign conv_fire = in_fire && (in_req_type == REQ_CONVERT);
  assign wr_fire   = in_fire && (in_req_type == REQ_PAL_WRITE)
                     && ({1'b0, in_entry_index} < PAL_LIM);

  // palette lookup decided at accept
  assign pal_lim = (pal_size_r > PAL_LIM) ? PAL_LIM : pal_size_r;
  assign pal_hit = (src_fmt_r == FMT_PAL) && (in_pixel_in < PIX_W'(pal_lim));

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      pal_mem[in_entry_index[AW-1:0]] <= in_entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_fire) begin
      pal_data_r <= pal_mem[in_pixel_in[AW-1:0]];
      s1_pixel_r <= in_pixel_in;
      s1_hit_r   <= pal_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= conv_fire;
    end
  end

  // a paletted source is converted as ARGB8
  assign s1_pix     = s1_hit_r ? pal_data_r : s1_pixel_r;
  assign s1_fmt.src = (src_fmt_r == FMT_PAL) ? FMT_ARGB8 : src_fmt_r;
  assign s1_fmt.dst = dst_fmt_r;

  pfc_convert u_convert (
    .fmt       (s1_fmt),
    .pixel     (s1_pix),
    .pixel_out (conv_pixel)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_pixel_r <= conv_pixel;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

`ifndef ASSERT_OFF
  a_conv_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    conv_fire |=> s1_valid_r)
    else $error("accepted conversion word did not reach stage one");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_fire && !s1_valid_r) |=> !s1_valid_r)
    else $error("palette write produced a conversion word");

  a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_pixel_r)))
    else $error("stage one word lost during output stall");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline valid not cleared by reset");
`endif

endmodule

// ===== hw/rtl/pfc_convert.sv =====
module pfc_convert (
  input  pfc_pkg::pfc_fmt_t          fmt,
  input  logic [pfc_pkg::PIX_W-1:0]  pixel,
  output logic [pfc_pkg::PIX_W-1:0]  pixel_out
);
  import pfc_pkg::*;

  logic [7:0]       r;
  logic [7:0]       g;
  logic [7:0]       b;
  logic [7:0]       a;
  logic             a1;
  logic             has_color;
  logic [15:0]      lum;
  logic [PIX_W-1:0] packed_pix;

  function automatic logic [7:0] wide5(input logic [4:0] v);
    wide5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] wide6(input logic [5:0] v);
    wide6 = {v, v[5:4]};
  endfunction

  // unpack source into 8-bit channels
  always_comb begin
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    a = 8'hFF;
    has_color = 1'b1;
    case (fmt.src)
      FMT_ARGB8: begin
        a = pixel[31:24]; r = pixel[23:16]; g = pixel[15:8]; b = pixel[7:0];
      end
      FMT_XRGB8, FMT_RGB8: begin
        r = pixel[23:16]; g = pixel[15:8]; b = pixel[7:0];
      end
      FMT_ABGR8: begin
        a = pixel[31:24]; b = pixel[23:16]; g = pixel[15:8]; r = pixel[7:0];
      end
      FMT_XBGR8, FMT_BGR8: begin
        b = pixel[23:16]; g = pixel[15:8]; r = pixel[7:0];
      end
      FMT_RGBA8: begin
        r = pixel[31:24]; g = pixel[23:16]; b = pixel[15:8]; a = pixel[7:0];
      end
      FMT_RGBX8: begin
        r = pixel[31:24]; g = pixel[23:16]; b = pixel[15:8];
      end
      FMT_BGRA8: begin
        b = pixel[31:24]; g = pixel[23:16]; r = pixel[15:8]; a = pixel[7:0];
      end
      FMT_BGRX8: begin
        b = pixel[31:24]; g = pixel[23:16]; r = pixel[15:8];
      end
      FMT_ARGB5: begin
        a = {8{pixel[15]}};
        r = wide5(pixel[14:10]); g = wide5(pixel[9:5]); b = wide5(pixel[4:0]);
      end
      FMT_RGB5: begin
        r = wide5(pixel[14:10]); g = wide5(pixel[9:5]); b = wide5(pixel[4:0]);
      end
      FMT_ABGR5: begin
        a = {8{pixel[15]}};
        b = wide5(pixel[14:10]); g = wide5(pixel[9:5]); r = wide5(pixel[4:0]);
      end
      FMT_BGR5: begin
        b = wide5(pixel[14:10]); g = wide5(pixel[9:5]); r = wide5(pixel[4:0]);
      end
      FMT_RGBA5: begin
        a = {8{pixel[0]}};
        r = wide5(pixel[15:11]); g = wide5(pixel[10:6]); b = wide5(pixel[5:1]);
      end
      FMT_BGRA5: begin
        a = {8{pixel[0]}};
        b = wide5(pixel[15:11]); g = wide5(pixel[10:6]); r = wide5(pixel[5:1]);
      end
      FMT_RGB565: begin
        r = wide5(pixel[15:11]); g = wide6(pixel[10:5]); b = wide5(pixel[4:0]);
      end
      FMT_BGR565: begin
        b = wide5(pixel[15:11]); g = wide6(pixel[10:5]); r = wide5(pixel[4:0]);
      end
      FMT_L8: begin
        r = pixel[7:0]; g = pixel[7:0]; b = pixel[7:0];
      end
      default: has_color = 1'b0;
    endcase
  end

  assign a1  = |a;
  assign lum = 16'(r) * 16'd55 + 16'(g) * 16'd184 + 16'(b) * 16'd18;

  // repack into destination format
  always_comb begin
    case (fmt.dst)
      FMT_ARGB8:  packed_pix = {a, r, g, b};
      FMT_XRGB8:  packed_pix = {8'hFF, r, g, b};
      FMT_RGB8:   packed_pix = {8'h00, r, g, b};
      FMT_ABGR8:  packed_pix = {a, b, g, r};
      FMT_XBGR8:  packed_pix = {8'hFF, b, g, r};
      FMT_BGR8:   packed_pix = {8'h00, b, g, r};
      FMT_RGBA8:  packed_pix = {r, g, b, a};
      FMT_RGBX8:  packed_pix = {r, g, b, 8'hFF};
      FMT_BGRA8:  packed_pix = {b, g, r, a};
      FMT_BGRX8:  packed_pix = {b, g, r, 8'hFF};
      FMT_ARGB5:  packed_pix = {16'h0, a1, r[7:3], g[7:3], b[7:3]};
      FMT_RGB5:   packed_pix = {16'h0, 1'b0, r[7:3], g[7:3], b[7:3]};
      FMT_ABGR5:  packed_pix = {16'h0, a1, b[7:3], g[7:3], r[7:3]};
      FMT_BGR5:   packed_pix = {16'h0, 1'b0, b[7:3], g[7:3], r[7:3]};
      FMT_RGBA5:  packed_pix = {16'h0, r[7:3], g[7:3], b[7:3], a1};
      FMT_BGRA5:  packed_pix = {16'h0, b[7:3], g[7:3], r[7:3], a1};
      FMT_RGB565: packed_pix = {16'h0, r[7:3], g[7:2], b[7:3]};
      FMT_BGR565: packed_pix = {16'h0, b[7:3], g[7:2], r[7:3]};
      FMT_L8:     packed_pix = {24'h0, lum[15:8]};
      default:    packed_pix = '0;
    endcase
  end

  always_comb begin
    if (fmt.src == fmt.dst) begin
      pixel_out = pixel;
    end else if (!has_color) begin
      pixel_out = '0;
    end else begin
      pixel_out = packed_pix;
    end
  end

endmodule
